// ===== design/cxalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex ALU package
// Shared widths, codes, the cell payload type and the saturation function.
// ----------------------------------------------------------------------------
package cxalu_pkg;

   localparam int WORD_W  = 16;
   localparam int FRAC_W  = 8;
   localparam int PROD_W  = 2 * WORD_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int Q_W     = WORD_W + 2;
   localparam int REM_W   = SUM_W + FRAC_W;
   localparam int DS_W    = PROD_W + Q_W - 1;
   localparam int N_CELLS = Q_W;
   localparam int LATENCY = N_CELLS + 3;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              dz;
      logic              re_neg;
      logic              im_neg;
      logic [REM_W-1:0]  r_re;
      logic [REM_W-1:0]  r_im;
      logic [DS_W-1:0]   ds;
      logic [Q_W-1:0]    q_re;
      logic [Q_W-1:0]    q_im;
      logic [WORD_W-1:0] res_re;
      logic [WORD_W-1:0] res_im;
      status_type        res_st;
   } cell_type;

   // Returns the saturation flag above the saturated word.
   function automatic logic [WORD_W:0] sat_word(input logic neg,
                                                input logic [SUM_W-1:0] mag);
      logic [SUM_W-1:0]  lim;
      logic [SUM_W-1:0]  m;
      logic              sat;
      logic [WORD_W-1:0] w;
      lim = neg ? (SUM_W'(1) << (WORD_W - 1)) : ((SUM_W'(1) << (WORD_W - 1)) - SUM_W'(1));
      sat = mag > lim;
      m   = sat ? lim : mag;
      w   = neg ? (WORD_W'(0) - m[WORD_W-1:0]) : m[WORD_W-1:0];
      return {sat, w};
   endfunction

endpackage

// ===== design/cxalu_front.sv =====
// ----------------------------------------------------------------------------
// Complex ALU front end
// Forms products and sums, finishes add, subtract and multiply, and sets up
// the division chain.
// ----------------------------------------------------------------------------
module cxalu_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [1:0]                           req_opcode,
   input  logic signed [cxalu_pkg::WORD_W-1:0]  req_a_real,
   input  logic signed [cxalu_pkg::WORD_W-1:0]  req_a_imag,
   input  logic signed [cxalu_pkg::WORD_W-1:0]  req_b_real,
   input  logic signed [cxalu_pkg::WORD_W-1:0]  req_b_imag,
   output cxalu_pkg::cell_type                  cell_out
);

   localparam int W = cxalu_pkg::WORD_W;
   localparam int P = cxalu_pkg::PROD_W;
   localparam int S = cxalu_pkg::SUM_W;

   logic                s1_valid_ff;
   cxalu_pkg::opcode_type s1_op_ff, s1_op_in;
   logic signed [W:0]   s1_sre_ff, s1_sre_in, s1_sim_ff, s1_sim_in;
   logic signed [P-1:0] p_arbr_ff, p_aibi_ff, p_arbi_ff, p_aibr_ff, p_brbr_ff, p_bibi_ff;
   logic signed [P-1:0] p_arbr_in, p_aibi_in, p_arbi_in, p_aibr_in, p_brbr_in, p_bibi_in;
   cxalu_pkg::cell_type cell_ff, cell_in;

   always_comb begin
      s1_op_in  = cxalu_pkg::opcode_type'(req_opcode);
      if (s1_op_in == cxalu_pkg::OP_SUB) begin
         s1_sre_in = {req_a_real[W-1], req_a_real} - {req_b_real[W-1], req_b_real};
         s1_sim_in = {req_a_imag[W-1], req_a_imag} - {req_b_imag[W-1], req_b_imag};
      end else begin
         s1_sre_in = {req_a_real[W-1], req_a_real} + {req_b_real[W-1], req_b_real};
         s1_sim_in = {req_a_imag[W-1], req_a_imag} + {req_b_imag[W-1], req_b_imag};
      end
      p_arbr_in = req_a_real * req_b_real;
      p_aibi_in = req_a_imag * req_b_imag;
      p_arbi_in = req_a_real * req_b_imag;
      p_aibr_in = req_a_imag * req_b_real;
      p_brbr_in = req_b_real * req_b_real;
      p_bibi_in = req_b_imag * req_b_imag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_op_ff  <= s1_op_in;
      s1_sre_ff <= s1_sre_in;
      s1_sim_ff <= s1_sim_in;
      p_arbr_ff <= p_arbr_in;
      p_aibi_ff <= p_aibi_in;
      p_arbi_ff <= p_arbi_in;
      p_aibr_ff <= p_aibr_in;
      p_brbr_ff <= p_brbr_in;
      p_bibi_ff <= p_bibi_in;
   end

   logic signed [S-1:0] v_re, v_im, v_den;
   logic [S-1:0]        m_re, m_im;
   logic                n_re, n_im;
   logic [W:0]          w_re, w_im;

   always_comb begin
      v_re  = '0;
      v_im  = '0;
      case (s1_op_ff)
         cxalu_pkg::OP_MUL: begin
            v_re = {p_arbr_ff[P-1], p_arbr_ff} - {p_aibi_ff[P-1], p_aibi_ff};
            v_im = {p_arbi_ff[P-1], p_arbi_ff} + {p_aibr_ff[P-1], p_aibr_ff};
         end
         cxalu_pkg::OP_DIV: begin
            v_re = {p_arbr_ff[P-1], p_arbr_ff} + {p_aibi_ff[P-1], p_aibi_ff};
            v_im = {p_aibr_ff[P-1], p_aibr_ff} - {p_arbi_ff[P-1], p_arbi_ff};
         end
         default: begin
            v_re = S'(s1_sre_ff);
            v_im = S'(s1_sim_ff);
         end
      endcase
      v_den = {p_brbr_ff[P-1], p_brbr_ff} + {p_bibi_ff[P-1], p_bibi_ff};
      n_re  = v_re[S-1];
      n_im  = v_im[S-1];
      m_re  = n_re ? (S'(0) - v_re) : v_re;
      m_im  = n_im ? (S'(0) - v_im) : v_im;
      if (s1_op_ff == cxalu_pkg::OP_MUL) begin
         w_re = cxalu_pkg::sat_word(n_re, m_re >> cxalu_pkg::FRAC_W);
         w_im = cxalu_pkg::sat_word(n_im, m_im >> cxalu_pkg::FRAC_W);
      end else begin
         w_re = cxalu_pkg::sat_word(n_re, m_re);
         w_im = cxalu_pkg::sat_word(n_im, m_im);
      end

      cell_in.valid  = s1_valid_ff;
      cell_in.is_div = s1_op_ff == cxalu_pkg::OP_DIV;
      cell_in.dz     = v_den == '0;
      cell_in.re_neg = n_re;
      cell_in.im_neg = n_im;
      cell_in.r_re   = {m_re, {cxalu_pkg::FRAC_W{1'b0}}};
      cell_in.r_im   = {m_im, {cxalu_pkg::FRAC_W{1'b0}}};
      cell_in.ds     = {v_den[P-1:0], {(cxalu_pkg::Q_W - 1){1'b0}}};
      cell_in.q_re   = '0;
      cell_in.q_im   = '0;
      cell_in.res_re = w_re[W-1:0];
      cell_in.res_im = w_im[W-1:0];
      cell_in.res_st = (w_re[W] | w_im[W]) ? cxalu_pkg::ST_SAT : cxalu_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.is_div <= cell_in.is_div;
      cell_ff.dz     <= cell_in.dz;
      cell_ff.re_neg <= cell_in.re_neg;
      cell_ff.im_neg <= cell_in.im_neg;
      cell_ff.r_re   <= cell_in.r_re;
      cell_ff.r_im   <= cell_in.r_im;
      cell_ff.ds     <= cell_in.ds;
      cell_ff.q_re   <= cell_in.q_re;
      cell_ff.q_im   <= cell_in.q_im;
      cell_ff.res_re <= cell_in.res_re;
      cell_ff.res_im <= cell_in.res_im;
      cell_ff.res_st <= cell_in.res_st;
   end

   assign cell_out = cell_ff;

endmodule

// ===== design/cxalu_cell.sv =====
// ----------------------------------------------------------------------------
// Complex ALU division cell
// Produces one quotient bit per lane for divisions; always halves the divisor.
// ----------------------------------------------------------------------------
module cxalu_cell (
   input  logic                clock,
   input  logic                reset,
   input  cxalu_pkg::cell_type cell_in,
   output cxalu_pkg::cell_type cell_out
);

   localparam int DS_W = cxalu_pkg::DS_W;

   cxalu_pkg::cell_type nxt_in, nxt_ff;
   logic [DS_W-1:0]     r_re_x, r_im_x;
   logic                ge_re, ge_im;

   always_comb begin
      nxt_in = cell_in;
      r_re_x = DS_W'(cell_in.r_re);
      r_im_x = DS_W'(cell_in.r_im);
      ge_re  = r_re_x >= cell_in.ds;
      ge_im  = r_im_x >= cell_in.ds;
      if (cell_in.is_div) begin
         if (ge_re) begin
            nxt_in.r_re = cell_in.r_re - cxalu_pkg::REM_W'(cell_in.ds);
         end
         if (ge_im) begin
            nxt_in.r_im = cell_in.r_im - cxalu_pkg::REM_W'(cell_in.ds);
         end
         nxt_in.q_re = {cell_in.q_re[cxalu_pkg::Q_W-2:0], ge_re};
         nxt_in.q_im = {cell_in.q_im[cxalu_pkg::Q_W-2:0], ge_im};
      end
      nxt_in.ds = cell_in.ds >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_ff.valid <= 1'b0;
      end else begin
         nxt_ff.valid <= nxt_in.valid;
      end
      nxt_ff.is_div <= nxt_in.is_div;
      nxt_ff.dz     <= nxt_in.dz;
      nxt_ff.re_neg <= nxt_in.re_neg;
      nxt_ff.im_neg <= nxt_in.im_neg;
      nxt_ff.r_re   <= nxt_in.r_re;
      nxt_ff.r_im   <= nxt_in.r_im;
      nxt_ff.ds     <= nxt_in.ds;
      nxt_ff.q_re   <= nxt_in.q_re;
      nxt_ff.q_im   <= nxt_in.q_im;
      nxt_ff.res_re <= nxt_in.res_re;
      nxt_ff.res_im <= nxt_in.res_im;
      nxt_ff.res_st <= nxt_in.res_st;
   end

   assign cell_out = nxt_ff;

endmodule

// ===== design/complex_fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// Complex fixed-point ALU
// Adds, subtracts, multiplies or divides two complex Q8.8 operands.
//
// Channel   Ports                                   Handshake
// request   req_opcode, req_a_*, req_b_*            start high, busy low
// response  rsp_result_real/imag, rsp_status        rsp_valid, one cycle
//
// An item is accepted every cycle; busy is always low.
// Every result passes the front stages, then the 18 division cells in a row,
// one quotient bit per cell, then the output stage.
// Reset clears only the valid bits of the stages.
// The receiver cannot stall, so nothing ever waits in the pipeline.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_opcode,
   input  logic signed [cxalu_pkg::WORD_W-1:0]  req_a_real,
   input  logic signed [cxalu_pkg::WORD_W-1:0]  req_a_imag,
   input  logic signed [cxalu_pkg::WORD_W-1:0]  req_b_real,
   input  logic signed [cxalu_pkg::WORD_W-1:0]  req_b_imag,
   output logic                                 rsp_valid,
   output logic signed [cxalu_pkg::WORD_W-1:0]  rsp_result_real,
   output logic signed [cxalu_pkg::WORD_W-1:0]  rsp_result_imag,
   output logic [1:0]                           rsp_status
);

   localparam int W = cxalu_pkg::WORD_W;
   localparam int N = cxalu_pkg::N_CELLS;

   cxalu_pkg::cell_type chain [0:N];

   cxalu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .req_a_real (req_a_real),
      .req_a_imag (req_a_imag),
      .req_b_real (req_b_real),
      .req_b_imag (req_b_imag),
      .cell_out   (chain[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      cxalu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   cxalu_pkg::cell_type last;
   logic [W:0]          d_re, d_im;
   logic                valid_ff, valid_in;
   logic [W-1:0]        re_ff, re_in, im_ff, im_in;
   cxalu_pkg::status_type st_ff, st_in;

   always_comb begin
      last     = chain[N];
      valid_in = last.valid;
      d_re     = cxalu_pkg::sat_word(last.re_neg, cxalu_pkg::SUM_W'(last.q_re));
      d_im     = cxalu_pkg::sat_word(last.im_neg, cxalu_pkg::SUM_W'(last.q_im));
      re_in    = last.res_re;
      im_in    = last.res_im;
      st_in    = last.res_st;
      if (last.is_div) begin
         if (last.dz) begin
            re_in = '0;
            im_in = '0;
            st_in = cxalu_pkg::ST_DIVZ;
         end else begin
            re_in = d_re[W-1:0];
            im_in = d_im[W-1:0];
            st_in = (d_re[W] | d_im[W]) ? cxalu_pkg::ST_SAT : cxalu_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      re_ff <= re_in;
      im_ff <= im_in;
      st_ff <= st_in;
   end

   assign busy            = 1'b0;
   assign rsp_valid       = valid_ff;
   assign rsp_result_real = re_ff;
   assign rsp_result_imag = im_ff;
   assign rsp_status      = st_ff;

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, cxalu_pkg::LATENCY))
      else $error("Result without an accepted item.");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cxalu_pkg::ST_DIVZ) |->
         (rsp_result_real == '0 && rsp_result_imag == '0))
      else $error("Divide by zero result is not zero.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("Undefined status code.");

endmodule
